@@ rtl/brr_pkg.sv @@
package brr_pkg;

   // Command queue between the front end and the decode engine
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;

   // Result queue in front of the output port
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;

   // Width of the predictor sum before clamping
   localparam int ACC_WIDTH = 21;

   // Largest shift that scales the nibble; above it the nibble saturates
   localparam logic [3:0] SHIFT_LIMIT = 4'd12;

   localparam logic signed [15:0] LARGE_POS = 16'sd2048;
   localparam logic signed [15:0] LARGE_NEG = -16'sd2048;
   localparam logic signed [15:0] PCM_MIN   = -16'sd32768;
   localparam logic signed [15:0] PCM_MAX   = 16'sd32767;

   // Predictor filter codes from the header byte
   localparam logic [1:0] FILTER_NONE = 2'd0;
   localparam logic [1:0] FILTER_ONE  = 2'd1;
   localparam logic [1:0] FILTER_TWO  = 2'd2;
   localparam logic [1:0] FILTER_THREE = 2'd3;

   // One data byte together with the header state in force when it arrived
   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] shift_amount;
      logic [1:0] filter_select;
      logic       hdr_loop;
      logic       hdr_end;
   } cmd_type;

   // One decoded sample as it leaves through the result port
   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               second_of_pair;
      logic               block_end;
      logic               block_loop;
   } rsp_type;

endpackage

@@ rtl/brr_front.sv @@
module brr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        data_byte,
   input  logic              is_header,
   input  logic              push,
   output logic              full,
   output logic              cmd_valid,
   output brr_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   logic [3:0] shift_ff;
   logic [3:0] shift_in;
   logic [1:0] filter_ff;
   logic [1:0] filter_in;
   logic       loop_ff;
   logic       loop_in;
   logic       end_ff;
   logic       end_in;

   brr_pkg::cmd_type             entry_ff [brr_pkg::CMD_DEPTH];
   logic [brr_pkg::CMD_PTR_W-1:0] wr_ptr_ff;
   logic [brr_pkg::CMD_PTR_W-1:0] wr_ptr_in;
   logic [brr_pkg::CMD_PTR_W-1:0] rd_ptr_ff;
   logic [brr_pkg::CMD_PTR_W-1:0] rd_ptr_in;
   logic [brr_pkg::CMD_PTR_W:0]   count_ff;
   logic [brr_pkg::CMD_PTR_W:0]   count_in;

   logic             beat;
   logic             hdr_beat;
   logic             data_beat;
   brr_pkg::cmd_type new_cmd;

   // Classify the accepted beat
   assign full      = (count_ff == (brr_pkg::CMD_PTR_W+1)'(brr_pkg::CMD_DEPTH));
   assign beat      = push && !full;
   assign hdr_beat  = beat && is_header;
   assign data_beat = beat && !is_header;

   // Latch the header fields
   always_comb begin
      shift_in  = shift_ff;
      filter_in = filter_ff;
      loop_in   = loop_ff;
      end_in    = end_ff;
      if (hdr_beat) begin
         shift_in  = data_byte[7:4];
         filter_in = data_byte[3:2];
         loop_in   = data_byte[1];
         end_in    = data_byte[0];
      end
   end

   // Snapshot the header state with each data byte
   always_comb begin
      new_cmd.data_byte     = data_byte;
      new_cmd.shift_amount  = shift_ff;
      new_cmd.filter_select = filter_ff;
      new_cmd.hdr_loop      = loop_ff;
      new_cmd.hdr_end       = end_ff;
   end

   // Advance the queue pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (data_beat) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (data_beat && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!data_beat && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '0;
         filter_ff <= '0;
         loop_ff   <= 1'b0;
         end_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         shift_ff  <= shift_in;
         filter_ff <= filter_in;
         loop_ff   <= loop_in;
         end_ff    <= end_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (data_beat) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/brr_back.sv @@
module brr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  brr_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output brr_pkg::rsp_type  rsp
);

   logic                                 phase_ff;
   logic                                 phase_in;
   logic signed [15:0]                   hist_newer_ff;
   logic signed [15:0]                   hist_newer_in;
   logic signed [15:0]                   hist_older_ff;
   logic signed [15:0]                   hist_older_in;

   logic                                 step;
   logic [3:0]                           nibble;
   logic signed [15:0]                   nib_ext;
   logic signed [15:0]                   nib_shl;
   logic signed [15:0]                   scaled;
   logic signed [brr_pkg::ACC_WIDTH-1:0] s_x;
   logic signed [brr_pkg::ACC_WIDTH-1:0] p1_x;
   logic signed [brr_pkg::ACC_WIDTH-1:0] p2_x;
   logic signed [brr_pkg::ACC_WIDTH-1:0] p1_x3;
   logic signed [brr_pkg::ACC_WIDTH-1:0] p1_x13;
   logic signed [brr_pkg::ACC_WIDTH-1:0] p2_x3;
   logic signed [brr_pkg::ACC_WIDTH-1:0] acc;
   logic signed [15:0]                   clamped;
   logic signed [15:0]                   sample;

   assign step     = cmd_valid && !rsp_full;
   assign rsp_push = step;
   assign cmd_pop  = step && phase_ff;

   // Pick the nibble, high one first
   assign nibble = phase_ff ? cmd.data_byte[3:0] : cmd.data_byte[7:4];

   // Scale the nibble, saturating for large shifts
   always_comb begin
      nib_ext = {{12{nibble[3]}}, nibble};
      nib_shl = nib_ext <<< cmd.shift_amount;
      if (cmd.shift_amount <= brr_pkg::SHIFT_LIMIT) begin
         scaled = nib_shl >>> 1;
      end else if (nibble[3]) begin
         scaled = brr_pkg::LARGE_NEG;
      end else begin
         scaled = brr_pkg::LARGE_POS;
      end
   end

   // Widen the operands and form the constant multiples
   always_comb begin
      s_x    = {{(brr_pkg::ACC_WIDTH-16){scaled[15]}}, scaled};
      p1_x   = {{(brr_pkg::ACC_WIDTH-16){hist_newer_ff[15]}}, hist_newer_ff};
      p2_x   = {{(brr_pkg::ACC_WIDTH-16){hist_older_ff[15]}}, hist_older_ff};
      p1_x3  = (p1_x <<< 1) + p1_x;
      p1_x13 = (p1_x <<< 3) + (p1_x <<< 2) + p1_x;
      p2_x3  = (p2_x <<< 1) + p2_x;
   end

   // Apply the predictor filter
   always_comb begin
      unique case (cmd.filter_select)
         brr_pkg::FILTER_NONE: begin
            acc = s_x;
         end
         brr_pkg::FILTER_ONE: begin
            acc = s_x + p1_x - (p1_x >>> 4);
         end
         brr_pkg::FILTER_TWO: begin
            acc = s_x + (p1_x <<< 1) - (p1_x3 >>> 5) - p2_x + (p2_x >>> 4);
         end
         brr_pkg::FILTER_THREE: begin
            acc = s_x + (p1_x <<< 1) - (p1_x13 >>> 6) - p2_x + (p2_x3 >>> 4);
         end
         default: begin
            acc = s_x;
         end
      endcase
   end

   // Clamp to 16 bits and clear the low bit
   always_comb begin
      if (acc < (brr_pkg::ACC_WIDTH)'(brr_pkg::PCM_MIN)) begin
         clamped = brr_pkg::PCM_MIN;
      end else if (acc > (brr_pkg::ACC_WIDTH)'(brr_pkg::PCM_MAX)) begin
         clamped = brr_pkg::PCM_MAX;
      end else begin
         clamped = acc[15:0];
      end
      sample = {clamped[15:1], 1'b0};
   end

   always_comb begin
      rsp.pcm_sample     = sample;
      rsp.second_of_pair = phase_ff;
      rsp.block_end      = cmd.hdr_end;
      rsp.block_loop     = cmd.hdr_loop;
   end

   // Advance the history and the nibble phase on each produced sample
   always_comb begin
      phase_in      = phase_ff;
      hist_newer_in = hist_newer_ff;
      hist_older_in = hist_older_ff;
      if (step) begin
         phase_in      = !phase_ff;
         hist_newer_in = sample;
         hist_older_in = hist_newer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         hist_newer_ff <= '0;
         hist_older_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         hist_newer_ff <= hist_newer_in;
         hist_older_ff <= hist_older_in;
      end
   end

`ifndef SYNTH
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff))
      else $error("nibble phase moved without a sample");

   a_pop_on_second: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (phase_ff && rsp_push))
      else $error("command released before its second sample");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      step |=> (hist_older_ff == $past(hist_newer_ff)))
      else $error("history did not shift on a sample");

   a_low_bit_clear: assert property (@(posedge clock) disable iff (reset)
      !hist_newer_ff[0])
      else $error("stored sample has its low bit set");
`endif

endmodule

@@ rtl/brr_rsp_queue.sv @@
module brr_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  brr_pkg::rsp_type  wr_data,
   output logic              q_full,
   output logic              q_empty,
   input  logic              rd_en,
   output brr_pkg::rsp_type  rd_data
);

   brr_pkg::rsp_type              entry_ff [brr_pkg::RSP_DEPTH];
   logic [brr_pkg::RSP_PTR_W-1:0] wr_ptr_ff;
   logic [brr_pkg::RSP_PTR_W-1:0] wr_ptr_in;
   logic [brr_pkg::RSP_PTR_W-1:0] rd_ptr_ff;
   logic [brr_pkg::RSP_PTR_W-1:0] rd_ptr_in;
   logic [brr_pkg::RSP_PTR_W:0]   count_ff;
   logic [brr_pkg::RSP_PTR_W:0]   count_in;
   logic                          wr_beat;
   logic                          rd_beat;

   assign q_full  = (count_ff == (brr_pkg::RSP_PTR_W+1)'(brr_pkg::RSP_DEPTH));
   assign q_empty = (count_ff == '0);
   assign wr_beat = wr_en && !q_full;
   assign rd_beat = rd_en && !q_empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_beat) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (rd_beat) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr_beat && !rd_beat) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_beat && rd_beat) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (wr_beat) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/brr_adpcm_block_decoder_top.sv @@
// BRR ADPCM block decoder. Push one stream byte per beat, flagging header bytes with
// req_is_header; a header sets shift, filter, loop and end for the bytes after it and
// gives no result, and each data byte gives two 16-bit samples, high nibble first, with
// rsp_second_of_pair set on the second. A data byte gives its two samples one after the
// other, because each sample feeds the predictor history of the next, so a byte leaves
// the byte queue only with its second sample. A two-entry byte queue lets the input run
// ahead of the decoder, and a four-entry result queue holds samples while pop is low.
// A data byte is registered in the byte queue; each sample is registered in the result
// queue, whose head drives the result ports.
module brr_adpcm_block_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_data_byte,
   input  logic               req_is_header,
   input  logic               push,
   output logic               full,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_second_of_pair,
   output logic               rsp_block_end,
   output logic               rsp_block_loop,
   output logic               empty,
   input  logic               pop
);

   logic             cmd_valid;
   logic             cmd_pop;
   brr_pkg::cmd_type cmd;
   logic             rsp_full;
   logic             rsp_push;
   brr_pkg::rsp_type rsp_new;
   brr_pkg::rsp_type rsp_head;

   brr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_data_byte),
      .is_header (req_is_header),
      .push      (push),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   brr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   brr_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_new),
      .q_full  (rsp_full),
      .q_empty (empty),
      .rd_en   (pop),
      .rd_data (rsp_head)
   );

   assign rsp_pcm_sample     = rsp_head.pcm_sample;
   assign rsp_second_of_pair = rsp_head.second_of_pair;
   assign rsp_block_end      = rsp_head.block_end;
   assign rsp_block_loop     = rsp_head.block_loop;

endmodule

@@ test/brr_sample_checker.sv @@
module brr_sample_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_data_byte,
   input  logic               req_is_header,
   input  logic               push,
   input  logic               full,
   input  logic signed [15:0] rsp_pcm_sample,
   input  logic               rsp_second_of_pair,
   input  logic               rsp_block_end,
   input  logic               rsp_block_loop,
   input  logic               empty,
   input  logic               pop,
   output int                 fail_count,
   output int                 waiting,
   output int                 samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Header state and predictor history as the decoder should hold them
   logic [3:0]         cur_shift;
   logic [1:0]         cur_filter;
   logic               cur_loop;
   logic               cur_end;
   logic signed [15:0] hist_last;
   logic signed [15:0] hist_prev;

   brr_pkg::rsp_type expected_samples[$];
   int               mismatch_total;
   int               checked_total;

   // Decode one nibble with the current header state and advance the history
   function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
      int s;
      int p1;
      int p2;
      s  = int'(nib);
      p1 = int'(hist_last);
      p2 = int'(hist_prev);
      if (s >= 8) s -= 16;
      if (cur_shift <= brr_pkg::SHIFT_LIMIT)
         s = (s * (1 << cur_shift)) >>> 1;
      else
         s = (s < 0) ? int'(brr_pkg::LARGE_NEG) : int'(brr_pkg::LARGE_POS);
      case (cur_filter)
         brr_pkg::FILTER_ONE: begin
            s += p1 - (p1 >>> 4);
         end
         brr_pkg::FILTER_TWO: begin
            s += 2 * p1 - ((3 * p1) >>> 5) - p2 + (p2 >>> 4);
         end
         brr_pkg::FILTER_THREE: begin
            s += 2 * p1 - ((13 * p1) >>> 6) - p2 + ((3 * p2) >>> 4);
         end
         default: begin
         end
      endcase
      if (s < int'(brr_pkg::PCM_MIN)) s = int'(brr_pkg::PCM_MIN);
      if (s > int'(brr_pkg::PCM_MAX)) s = int'(brr_pkg::PCM_MAX);
      // clear the low bit
      s = s & ~1;
      hist_prev = hist_last;
      hist_last = s[15:0];
      return s[15:0];
   endfunction

   // Take one accepted stream byte: latch a header or queue two samples
   task automatic predict_byte(input logic [7:0] b, input logic hdr);
      brr_pkg::rsp_type smp;
      if (hdr) begin
         cur_shift  = b[7:4];
         cur_filter = b[3:2];
         cur_loop   = b[1];
         cur_end    = b[0];
      end else begin
         smp.pcm_sample     = decode_nibble(b[7:4]);
         smp.second_of_pair = 1'b0;
         smp.block_end      = cur_end;
         smp.block_loop     = cur_loop;
         expected_samples.push_back(smp);
         smp.pcm_sample     = decode_nibble(b[3:0]);
         smp.second_of_pair = 1'b1;
         expected_samples.push_back(smp);
      end
   endtask

   task automatic compare_field(input string name, input logic signed [15:0] want,
                                input logic signed [15:0] got);
      if (got !== want) begin
         mismatch_total++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare one popped sample against the oldest prediction
   task automatic check_sample();
      brr_pkg::rsp_type want;
      if (expected_samples.size() == 0) begin
         mismatch_total++;
         $display("%0t: unexpected sample: expected none, actual %0d", $time,
                  rsp_pcm_sample);
      end else begin
         want = expected_samples.pop_front();
         compare_field("pcm_sample", want.pcm_sample, rsp_pcm_sample);
         compare_field("second_of_pair", {15'd0, want.second_of_pair},
                       {15'd0, rsp_second_of_pair});
         compare_field("block_end", {15'd0, want.block_end}, {15'd0, rsp_block_end});
         compare_field("block_loop", {15'd0, want.block_loop}, {15'd0, rsp_block_loop});
      end
      checked_total++;
   endtask

   // Sample both channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         cur_shift  = '0;
         cur_filter = brr_pkg::FILTER_NONE;
         cur_loop   = 1'b0;
         cur_end    = 1'b0;
         hist_last  = '0;
         hist_prev  = '0;
         expected_samples.delete();
      end else begin
         if (push && !full) predict_byte(req_data_byte, req_is_header);
         if (pop && !empty) check_sample();
      end
      fail_count      <= mismatch_total;
      waiting         <= expected_samples.size();
      samples_checked <= checked_total;
   end

endmodule

@@ test/tb_brr_adpcm_block_decoder_top.sv @@
module tb_brr_adpcm_block_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_BYTES   = 530;
   localparam int DRAIN_CYCLES  = 20;

   logic               clock;
   logic               reset;
   logic [7:0]         req_data_byte;
   logic               req_is_header;
   logic               push;
   logic               full;
   logic signed [15:0] rsp_pcm_sample;
   logic               rsp_second_of_pair;
   logic               rsp_block_end;
   logic               rsp_block_loop;
   logic               empty;
   logic               pop;

   int fail_count;
   int waiting;
   int samples_checked;

   int send_idle_pct;
   int recv_idle_pct;
   int headers_sent;
   int data_sent;
   int stall_cycles;

   brr_adpcm_block_decoder_top uut (.*);

   brr_sample_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: hold pop low for the idle share of cycles
   always @(posedge clock) begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Push one stream byte, idling at random first, and wait for its beat
   task automatic send_byte(input logic [7:0] b, input logic hdr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_data_byte <= b;
      req_is_header <= hdr;
      push          <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      if (hdr) headers_sent++;
      else     data_sent++;
   endtask

   // One block: a header and normally eight data bytes; now and then a
   // short or long block or a stray header in the middle
   task automatic send_random_block();
      logic [3:0] shift;
      int         len;
      shift = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, 12));
      send_byte({shift, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))}, 1'b1);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : 8;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 39) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic run_phase(input int s_idle, input int r_idle);
      int start;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      start = headers_sent + data_sent;
      while (headers_sent + data_sent - start < PHASE_BYTES) send_random_block();
   endtask

   initial begin
      reset         <= 1'b1;
      push          <= 1'b0;
      pop           <= 1'b0;
      req_data_byte <= '0;
      req_is_header <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      headers_sent  = 0;
      data_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: data before any header decodes with shift 0 and no filter
      send_idle_pct = 24;
      recv_idle_pct = 71;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h87, 1'b0);
      // largest scaling shift, loop flag set
      send_byte({4'd12, brr_pkg::FILTER_NONE, 1'b1, 1'b0}, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      // shifts above the limit saturate to plus or minus 2048
      send_byte({4'd13, brr_pkg::FILTER_NONE, 1'b0, 1'b1}, 1'b1);
      send_byte(8'h08, 1'b0);
      send_byte({4'd15, brr_pkg::FILTER_NONE, 1'b1, 1'b1}, 1'b1);
      send_byte(8'hF7, 1'b0);
      // drive the filters into both clamps
      send_byte({4'd12, brr_pkg::FILTER_ONE, 1'b0, 1'b0}, 1'b1);
      send_byte(8'h77, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte({4'd12, brr_pkg::FILTER_TWO, 1'b1, 1'b1}, 1'b1);
      send_byte(8'h88, 1'b0);
      send_byte(8'h88, 1'b0);
      send_byte({4'd11, brr_pkg::FILTER_THREE, 1'b0, 1'b1}, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h1E, 1'b0);
      // back-to-back headers: only the second applies, history is kept
      send_byte({4'd0, brr_pkg::FILTER_THREE, 1'b1, 1'b0}, 1'b1);
      send_byte({4'd14, brr_pkg::FILTER_TWO, 1'b0, 1'b0}, 1'b1);
      send_byte(8'h3C, 1'b0);

      // Random blocks under three idling patterns
      run_phase(24, 71);
      run_phase(71, 24);
      run_phase(0, 0);
      push <= 1'b0;

      // Drain the result queue, then give stray samples a chance to show
      while (waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Pushed %0d data bytes and %0d headers over three idling patterns;",
               data_sent, headers_sent);
      $display("compared %0d samples, %0d mismatches.", samples_checked, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/brr_pkg.sv
rtl/brr_front.sv
rtl/brr_back.sv
rtl/brr_rsp_queue.sv
rtl/brr_adpcm_block_decoder_top.sv
test/brr_sample_checker.sv
test/tb_brr_adpcm_block_decoder_top.sv
